FILE: hw/rtl/cfp_pkg.sv
// Shared constants and types for the command frame parser.
package cfp_pkg;

  localparam logic [7:0] SyncA     = 8'hAA;
  localparam logic [7:0] SyncB     = 8'hFF;
  localparam logic [7:0] TypeGain  = 8'h02;
  localparam logic [7:0] TypeSpeed = 8'h03;

  localparam logic [2:0] LenGain  = 3'd3;
  localparam logic [2:0] LenSpeed = 3'd4;

  localparam logic [1:0] FtNone  = 2'd0;
  localparam logic [1:0] FtGain  = 2'd1;
  localparam logic [1:0] FtSpeed = 2'd2;

  localparam logic KindGain  = 1'b0;
  localparam logic KindSpeed = 1'b1;

  // Decoded frame as it leaves the parser.
  typedef struct packed {
    logic               frame_kind;
    logic [7:0]         gain_p;
    logic [7:0]         gain_i;
    logic [7:0]         gain_d;
    logic signed [15:0] speed_first;
    logic signed [15:0] speed_second;
  } result_t;

endpackage

FILE: hw/rtl/cfp_if.sv
// Handshake interfaces for the received byte stream and the decoded frames.
interface cfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_result_if;
  logic               valid;
  logic               ready;
  logic               frame_kind;
  logic [7:0]         gain_p;
  logic [7:0]         gain_i;
  logic [7:0]         gain_d;
  logic signed [15:0] speed_first;
  logic signed [15:0] speed_second;

  modport source (output valid, output frame_kind, output gain_p, output gain_i,
                  output gain_d, output speed_first, output speed_second,
                  input ready);
  modport sink   (input valid, input frame_kind, input gain_p, input gain_i,
                  input gain_d, input speed_first, input speed_second,
                  output ready);
endinterface

FILE: hw/rtl/cfp_in_stage.sv
// Input register for received bytes.
module cfp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfp_byte_if.sink   rx_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  import cfp_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  // Refill when empty or when the parser consumes the held byte this cycle.
  assign load     = !valid_q || take_i;
  assign rx_i.ready = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && rx_i.valid) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

FILE: hw/rtl/cfp_parse.sv
// Frame parser state, payload store and result register.
module cfp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [7:0]     byte_i,
  output logic           take_o,
  cfp_result_if.source   res_o
);
  import cfp_pkg::*;

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhSyncB   = 4'd1;
  localparam logic [3:0] PhType    = 4'd2;
  localparam logic [3:0] PhPayload = 4'd3;

  logic [3:0] phase_q, phase_d;
  logic [2:0] len_q, len_d;
  logic [1:0] ftype_q, ftype_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] store_q [4];
  logic [7:0] store_d [4];

  logic       res_valid_q;
  result_t    res_q, res_d;
  logic       adv, take, fire;
  logic [3:0] ph_trl_b, ph_trl_a;
  logic [2:0] idx_inc;

  assign adv    = !res_valid_q || res_o.ready;
  assign take   = valid_i && adv;
  assign take_o = take;

  assign ph_trl_b = PhPayload + {1'b0, len_q};
  assign ph_trl_a = ph_trl_b + 4'd1;
  assign idx_inc  = idx_q + 3'd1;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    ftype_d = ftype_q;
    idx_d   = idx_q;
    store_d = store_q;
    fire    = 1'b0;
    res_d   = '0;
    if (phase_q == PhIdle && byte_i == SyncA) begin
      phase_d = PhSyncB;
    end else if (phase_q == PhSyncB && byte_i == SyncB) begin
      phase_d = PhType;
    end else if (phase_q == PhType) begin
      if (byte_i == TypeGain) begin
        len_d   = LenGain;
        ftype_d = FtGain;
        idx_d   = '0;
        phase_d = PhPayload;
      end else if (byte_i == TypeSpeed) begin
        len_d   = LenSpeed;
        ftype_d = FtSpeed;
        idx_d   = '0;
        phase_d = PhPayload;
      end else begin
        phase_d = PhIdle;
        len_d   = '0;
        ftype_d = FtNone;
        idx_d   = '0;
      end
    end else if (len_q != '0 && phase_q >= PhPayload && phase_q < ph_trl_b) begin
      // Payload bytes are stored unchecked.
      store_d[idx_q[1:0]] = byte_i;
      phase_d = phase_q + 4'd1;
      idx_d   = (idx_inc >= len_q) ? 3'd0 : idx_inc;
    end else if (len_q != '0 && phase_q == ph_trl_b && byte_i == SyncB) begin
      phase_d = phase_q + 4'd1;
    end else if (len_q != '0 && phase_q == ph_trl_a && byte_i == SyncA) begin
      if (ftype_q == FtGain) begin
        fire             = 1'b1;
        res_d.frame_kind = KindGain;
        res_d.gain_p     = store_q[0];
        res_d.gain_i     = store_q[1];
        res_d.gain_d     = store_q[2];
      end else if (ftype_q == FtSpeed) begin
        fire               = 1'b1;
        res_d.frame_kind   = KindSpeed;
        res_d.speed_first  = {store_q[1], store_q[0]};
        res_d.speed_second = {store_q[3], store_q[2]};
      end
      phase_d = PhIdle;
      len_d   = '0;
      ftype_d = FtNone;
      idx_d   = '0;
    end else begin
      // Mismatch: back to idle, byte dropped.
      phase_d = PhIdle;
      len_d   = '0;
      ftype_d = FtNone;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      len_q   <= '0;
      ftype_q <= FtNone;
      idx_q   <= '0;
      for (int k = 0; k < 4; k++) begin
        store_q[k] <= '0;
      end
    end else if (take) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      ftype_q <= ftype_d;
      idx_q   <= idx_d;
      store_q <= store_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= take && fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.frame_kind   = res_q.frame_kind;
  assign res_o.gain_p       = res_q.gain_p;
  assign res_o.gain_i       = res_q.gain_i;
  assign res_o.gain_d       = res_q.gain_d;
  assign res_o.speed_first  = res_q.speed_first;
  assign res_o.speed_second = res_q.speed_second;

`ifndef SYNTH
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= 4'd8)
    else $error("phase beyond trailer");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> (len_q == '0 && ftype_q == FtNone && idx_q == '0))
    else $error("idle with frame context");

  a_gain_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.frame_kind == KindGain) |->
      (res_q.speed_first == '0 && res_q.speed_second == '0))
    else $error("gain frame with speed data");

  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.frame_kind == KindSpeed) |->
      (res_q.gain_p == '0 && res_q.gain_i == '0 && res_q.gain_d == '0))
    else $error("speed frame with gain data");

  a_fire_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && fire) |=> phase_q == PhIdle)
    else $error("parser not idle after frame end");
`endif

endmodule

FILE: hw/rtl/command_frame_parser_core.sv
// Top level of the command frame parser.
//
// Usage:
//   rx_i takes received link bytes, one per transaction (valid/ready).
//   Frames are AA FF, type, payload, FF AA. Type 02 carries P, I, D gain
//   bytes; type 03 carries two little-endian signed 16-bit speeds.
//   res_o gives one transaction per completed frame: frame_kind plus the
//   decoded fields; fields unused by the frame kind read as zero.
//   A mismatched header, type or trailer byte returns the parser to idle
//   and the byte is dropped.
// Timing:
//   One byte per cycle sustained unless a result waits on res_o.ready.
//   A byte is held in the input register, then the parser updates its
//   state and, on the closing AA, loads the result register, which
//   drives res_o.
// Reset: the parser goes idle, payload store cleared, both registers empty.
// Stall: a waiting result holds and the parser takes no byte; if the input
// register is empty it still takes one more byte, then rx_i.ready stays low
// until res_o.ready returns.
module command_frame_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfp_byte_if.sink     rx_i,
  cfp_result_if.source res_o
);
  import cfp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_val;
  logic       take;

  cfp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (take),
    .valid_o (byte_valid),
    .byte_o  (byte_val)
  );

  cfp_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_valid),
    .byte_i  (byte_val),
    .take_o  (take),
    .res_o   (res_o)
  );

endmodule

FILE: tb/sv/command_frame_parser_core_test.sv
// Testbench for command_frame_parser_core: framed byte stream in, decoded frames checked out.
`timescale 1ns / 100ps

module command_frame_parser_core_test;
  import cfp_pkg::*;

  localparam int CycleLimit    = 200000;
  localparam int BytesPerPhase = 583;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 8;

  logic clk_i;
  logic rst_ni;

  cfp_byte_if   rx_if ();
  cfp_result_if res_if ();

  command_frame_parser_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Byte stream waiting to be sent, and decoded frames still to arrive.
  logic [7:0] rx_bytes_pending[$];
  result_t    frames_due[$];

  int bytes_queued   = 0;
  int bytes_accepted = 0;
  int fail_count     = 0;
  int cycle_count    = 0;
  int mode           = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  // Parser state as seen by the prediction.
  logic [3:0] prs_phase;
  logic [2:0] prs_len;
  logic [1:0] prs_type;
  logic [2:0] prs_idx;
  logic [7:0] prs_store[4];

  function automatic void parser_idle();
    prs_phase = 4'd0;
    prs_len   = 3'd0;
    prs_type  = FtNone;
    prs_idx   = 3'd0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    result_t frm;
    frm = '0;
    if (prs_phase == 4'd0 && b == SyncA) begin
      prs_phase = 4'd1;
    end else if (prs_phase == 4'd1 && b == SyncB) begin
      prs_phase = 4'd2;
    end else if (prs_phase == 4'd2) begin
      if (b == TypeGain) begin
        prs_len   = LenGain;
        prs_type  = FtGain;
        prs_idx   = 3'd0;
        prs_phase = 4'd3;
      end else if (b == TypeSpeed) begin
        prs_len   = LenSpeed;
        prs_type  = FtSpeed;
        prs_idx   = 3'd0;
        prs_phase = 4'd3;
      end else begin
        parser_idle();
      end
    end else if (prs_len != 0 && prs_phase >= 3 && prs_phase < 3 + prs_len) begin
      prs_store[prs_idx[1:0]] = b;
      prs_phase = prs_phase + 4'd1;
      prs_idx   = prs_idx + 3'd1;
      if (prs_idx >= prs_len) prs_idx = 3'd0;
    end else if (prs_len != 0 && prs_phase == 3 + prs_len && b == SyncB) begin
      prs_phase = prs_phase + 4'd1;
    end else if (prs_len != 0 && prs_phase == 4 + prs_len && b == SyncA) begin
      if (prs_type == FtGain) begin
        frm.frame_kind = KindGain;
        frm.gain_p     = prs_store[0];
        frm.gain_i     = prs_store[1];
        frm.gain_d     = prs_store[2];
        frames_due.push_back(frm);
      end else if (prs_type == FtSpeed) begin
        frm.frame_kind   = KindSpeed;
        frm.speed_first  = {prs_store[1], prs_store[0]};
        frm.speed_second = {prs_store[3], prs_store[2]};
        frames_due.push_back(frm);
      end
      parser_idle();
    end else begin
      parser_idle();
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // Payload values lean toward the sync bytes and the sign boundaries.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return SyncA;
      1: return SyncB;
      2: return 8'h00;
      3: return 8'h80;
      4: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_pending.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_directed();
    logic [7:0] seq[$];
    seq = '{
      // gain frame, payload at the extremes and equal to the sync bytes
      SyncA, SyncB, TypeGain, 8'h00, SyncB, SyncA, SyncB, SyncA,
      // speed frame: -32768 and +32767
      SyncA, SyncB, TypeSpeed, 8'h00, 8'h80, SyncB, 8'h7F, SyncB, SyncA,
      // unknown type byte
      SyncA, SyncB, 8'h05,
      // AA in place of the first trailer byte is dropped, not a new header
      SyncA, SyncB, TypeGain, 8'h11, 8'h22, 8'h33, SyncA
    };
    foreach (seq[i]) queue_byte(seq[i]);
  endtask

  task automatic queue_random_frame();
    logic [7:0] frm[$];
    logic [7:0] bad;
    int kind;
    int k;
    int keep;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) frm.push_back(pick_byte());
    end else begin
      frm.push_back(SyncA);
      frm.push_back(SyncB);
      if ($urandom_range(0, 1) != 0) begin
        frm.push_back(TypeSpeed);
        repeat (4) frm.push_back(pick_byte());
      end else begin
        frm.push_back(TypeGain);
        repeat (3) frm.push_back(pick_byte());
      end
      frm.push_back(SyncB);
      frm.push_back(SyncA);
      if (kind >= 82) begin
        // corrupt one header, type or trailer byte
        k = $urandom_range(0, 4);
        if (k >= 3) k = frm.size() - 5 + k;
        do bad = 8'($urandom_range(0, 255)); while (bad == frm[k]);
        frm[k] = bad;
      end else if (kind >= 74) begin
        keep = $urandom_range(1, frm.size() - 1);
        while (frm.size() > keep) frm.delete(frm.size() - 1);
      end
    end
    foreach (frm[i]) queue_byte(frm[i]);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Byte driver: predicts on every accepted transaction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        parse_byte(rx_if.rx_byte);
        bytes_accepted++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_bytes_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= rx_bytes_pending.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once a frame is waiting, so the input side backs up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (mode == 2 && !hold_done && res_if.valid) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Frame monitor.
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (frames_due.size() == 0) begin
          $error("frame_kind: unexpected frame, got %h", res_if.frame_kind);
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("frame_kind", 16'(want.frame_kind), 16'(res_if.frame_kind));
          check_field("gain_p", 16'(want.gain_p), 16'(res_if.gain_p));
          check_field("gain_i", 16'(want.gain_i), 16'(res_if.gain_i));
          check_field("gain_d", 16'(want.gain_d), 16'(res_if.gain_d));
          check_field("speed_first", want.speed_first, res_if.speed_first);
          check_field("speed_second", want.speed_second, res_if.speed_second);
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready  = 1'b0;
    parser_idle();
    foreach (prs_store[i]) prs_store[i] = 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int m = 0; m < 3; m++) begin
      mode          <= m;
      send_idle_pct <= (m == 0) ? 24 : (m == 1) ? 79 : 0;
      recv_idle_pct <= (m == 0) ? 79 : (m == 1) ? 24 : 0;
      if (m == 0) queue_directed();
      begin
        int target;
        target = bytes_queued + BytesPerPhase;
        while (bytes_queued < target) queue_random_frame();
      end
      while (bytes_accepted != bytes_queued) @(posedge clk_i);
      while (frames_due.size() != 0) @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
